FILE: hdl/fss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer package
// Shared types, register indexes, scoring constants and the case fold helper.
// ----------------------------------------------------------------------------
package fss_pkg;

	localparam int MAX_QUERY_DEF = 16;
	localparam int QLEN_W        = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int CHAR_W        = 8;
	localparam int SCORE_W       = 16;
	localparam int RUN_W         = 4;
	localparam int GAIN_W        = 7;
	localparam int LO_CHARS      = 8;

	localparam logic [GAIN_W-1:0] WORD_BONUS = GAIN_W'(10);
	localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;
	localparam logic [RUN_W-1:0]  RUN_MAX    = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUERY_LENGTH   = 2'd0,
		REG_QUERY_CHARS_LO = 2'd1,
		REG_QUERY_CHARS_HI = 2'd2
	} cfg_reg_e;

	// Query view handed to the match core: clamped length and the selected character.
	typedef struct packed {
		logic [QLEN_W-1:0] len;
		logic [CHAR_W-1:0] chr;
	} query_info_t;

	// Outcome of the current word, as it would stand if the word ends the candidate.
	typedef struct packed {
		logic               matched;
		logic [SCORE_W-1:0] score;
	} result_t;

	// Folds ASCII upper case letters to lower case; other bytes pass unchanged.
	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

FILE: hdl/fss_query_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Query register file
// Holds the query length and characters written through the config port and
// presents the clamped length and the character at the current query index.
// ----------------------------------------------------------------------------
module fss_query_regs import fss_pkg::*; #(
	parameter int MAX_QUERY = MAX_QUERY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [QLEN_W-1:0]     rd_index,
	output query_info_t           qinfo
);

	localparam int CH_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;

	logic [QLEN_W-1:0] query_length_q;
	logic [CHAR_W-1:0] chars_q [MAX_QUERY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_length_q <= '0;
		end else if (cfg_wr_en && cfg_index == REG_QUERY_LENGTH) begin
			query_length_q <= cfg_data[QLEN_W-1:0];
		end
	end

	for (genvar i = 0; i < MAX_QUERY; i++) begin : g_char
		if (i < LO_CHARS) begin : g_lo
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					chars_q[i] <= '0;
				end else if (cfg_wr_en && cfg_index == REG_QUERY_CHARS_LO) begin
					chars_q[i] <= cfg_data[CHAR_W*i +: CHAR_W];
				end
			end
		end else begin : g_hi
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					chars_q[i] <= '0;
				end else if (cfg_wr_en && cfg_index == REG_QUERY_CHARS_HI) begin
					chars_q[i] <= cfg_data[CHAR_W*(i-LO_CHARS) +: CHAR_W];
				end
			end
		end
	end

	always_comb begin
		qinfo.len = (query_length_q > QLEN_W'(MAX_QUERY)) ? QLEN_W'(MAX_QUERY)
		                                                   : query_length_q;
		qinfo.chr = (rd_index < QLEN_W'(MAX_QUERY)) ? chars_q[rd_index[CH_W-1:0]] : '0;
	end

endmodule

FILE: hdl/fss_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Match core
// Per-candidate state and the combinational score update for one candidate byte.
// ----------------------------------------------------------------------------
module fss_match_core import fss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              no_char,
	input  logic              last,
	input  query_info_t       qinfo,
	output logic [QLEN_W-1:0] rd_index,
	output result_t           result
);

	logic [QLEN_W-1:0]  query_index_q, query_index_d;
	logic [SCORE_W-1:0] score_q, score_d;
	logic [RUN_W-1:0]   run_q, run_d, run_inc;
	logic               prev_q, prev_d;
	logic               word_q, word_d;
	logic               hit, can_match;
	logic [GAIN_W-1:0]  gain;
	logic [SCORE_W:0]   delta, sum;
	logic [SCORE_W-1:0] score_sat;

	assign rd_index = query_index_q;

	always_comb begin
		can_match = query_index_q < qinfo.len;
		hit       = fold_case(char_code) == fold_case(qinfo.chr);
		run_inc   = (run_q == RUN_MAX) ? RUN_MAX : run_q + 1'b1;

		gain = GAIN_W'(1);
		if (word_q) begin
			gain = gain + WORD_BONUS;
		end
		if (prev_q) begin
			gain = gain + {run_inc, 2'b00} + GAIN_W'(run_inc);
		end

		// A miss subtracts one; the sum is one bit wider so underflow shows in the top bits.
		delta = hit ? (SCORE_W+1)'(gain) : '1;
		sum   = {score_q[SCORE_W-1], score_q} + delta;
		score_sat = (sum[SCORE_W] && !sum[SCORE_W-1]) ? {1'b1, {(SCORE_W-1){1'b0}}}
		                                              : sum[SCORE_W-1:0];

		query_index_d = query_index_q;
		score_d       = score_q;
		run_d         = run_q;
		prev_d        = prev_q;
		word_d        = word_q;
		if (!no_char) begin
			if (can_match) begin
				score_d = score_sat;
				prev_d  = hit;
				if (hit) begin
					run_d         = prev_q ? run_inc : '0;
					query_index_d = query_index_q + 1'b1;
				end
			end
			word_d = (char_code == CH_DASH) || (char_code == CH_UNDER);
		end

		result.matched = query_index_d >= qinfo.len;
		result.score   = result.matched ? score_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_index_q <= '0;
			score_q       <= '0;
			run_q         <= '0;
			prev_q        <= 1'b0;
			word_q        <= 1'b1;
		end else if (step_en) begin
			if (last) begin
				query_index_q <= '0;
				score_q       <= '0;
				run_q         <= '0;
				prev_q        <= 1'b0;
				word_q        <= 1'b1;
			end else begin
				query_index_q <= query_index_d;
				score_q       <= score_d;
				run_q         <= run_d;
				prev_q        <= prev_d;
				word_q        <= word_d;
			end
		end
	end

endmodule

FILE: hdl/fuzzy_subsequence_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fuzzy subsequence scorer
// Scores a streamed candidate string against a configured query with greedy,
// case-insensitive subsequence matching and reports match and score on last.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload                    Direction
//  -------  ---------------------  -------------------------  ---------
//  input    in_valid / in_ready    char_code, no_char, last   in
//  output   out_valid / out_ready  matched, score             out
//  config   cfg_wr_en              cfg_index, cfg_data        in
//
// One input word is accepted per cycle while no stalled output holds back a last
// word. A word is registered on acceptance and scored by the match core, whose
// state feedback loop (compare, gain and saturating add) is combinational; a
// result enters the output register as its last word leaves the input stage.
// Reset clears the query registers and the per-candidate state.
// A stalled output only holds back a registered word that carries last; words
// without last keep flowing while a result waits.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer import fss_pkg::*; #(
	parameter int MAX_QUERY = MAX_QUERY_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [CHAR_W-1:0]      char_code,
	input  logic                   no_char,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   matched,
	output logic signed [SCORE_W-1:0] score
);

	// Input stage register.
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              no_char_s1;
	logic              last_s1;
	logic              adv_s1;

	// Output register.
	logic               out_valid_q;
	logic               matched_q;
	logic [SCORE_W-1:0] score_q;

	query_info_t       qinfo;
	result_t           result;
	logic [QLEN_W-1:0] rd_index;

	// The registered word moves on unless it ends a candidate and the result
	// register is still occupied by an untaken result.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1    <= char_code;
			no_char_s1 <= no_char;
			last_s1    <= last;
		end
	end

	fss_query_regs #(
		.MAX_QUERY (MAX_QUERY)
	) u_query_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rd_index  (rd_index),
		.qinfo     (qinfo)
	);

	fss_match_core u_match_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv_s1),
		.char_code (char_s1),
		.no_char   (no_char_s1),
		.last      (last_s1),
		.qinfo     (qinfo),
		.rd_index  (rd_index),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			matched_q <= result.matched;
			score_q   <= result.score;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign score     = signed'(score_q);

	// A result that did not match always carries a zero score.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !matched_q |-> score_q == '0)
		else $error("unmatched result with nonzero score");

	// The query index never runs past the largest supported query.
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_index <= QLEN_W'(MAX_QUERY))
		else $error("query index beyond query storage");

	// A new result only appears after a word carrying last left the input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("result without a last word");

	// An accepted word is always held in the input stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted word lost");

endmodule
